// File: sv/slcd_pkg.sv
// ----------------------------------------------------------------------------
// Serial monochrome LCD controller package
// Shared types, codes and constants for the controller, datapath and channels.
// ----------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

   // Panel geometry defaults
   localparam int DEF_COLUMNS = 84;
   localparam int DEF_ROWS    = 48;

   // Luminance levels
   localparam logic [7:0] LUM_OFF  = 8'd230;
   localparam logic [7:0] LUM_FULL = 8'd127;

   // Command byte decode masks
   localparam logic [7:0] CMD_FUNC_MASK = 8'hF8;
   localparam logic [7:0] CMD_FUNC_SET  = 8'h20;
   localparam logic [7:0] CMD_FUNC_EXT  = 8'h01;
   localparam logic [7:0] CMD_HIGH_BIT  = 8'h80;
   localparam logic [7:0] CMD_SET_Y     = 8'h40;
   localparam logic [7:0] CMD_RESERVED  = 8'h10;
   localparam logic [7:0] CMD_DISPLAY   = 8'h08;
   localparam logic [7:0] CMD_INV_BITS  = 8'h05;
   localparam logic [7:0] CMD_X_MASK    = 8'h7F;
   localparam logic [7:0] CMD_Y_MASK    = 8'h07;

   // Input item kinds
   typedef enum logic [2:0] {
      KIND_CLOCK = 3'd0,
      KIND_DIN   = 3'd1,
      KIND_DC    = 3'd2,
      KIND_RST   = 3'd3,
      KIND_SEL   = 3'd4,
      KIND_READ  = 3'd5
   } kind_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_FINISH = 2'd2
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take_item;
      logic clear_step;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic clear_req;
   } dp_status_type;

endpackage

`default_nettype wire

// File: sv/slcd_if.sv
// ----------------------------------------------------------------------------
// Serial monochrome LCD controller channels
// Valid/ready channel interfaces for pin-event items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface slcd_req_if import slcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic       level;
   logic [6:0] read_x;
   logic [5:0] read_y;

   modport source (output valid, kind, level, read_x, read_y, input ready);
   modport sink   (input valid, kind, level, read_x, read_y, output ready);
endinterface

interface slcd_rsp_if import slcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       pixel_lit;
   logic [7:0] luminance;
   logic [6:0] contrast_now;
   logic       inverted;
   logic       extended_mode;
   logic [6:0] column;
   logic [2:0] bank;
   logic       byte_done;
   logic       frame_changed;

   modport source (output valid, pixel_lit, luminance, contrast_now, inverted,
                   extended_mode, column, bank, byte_done, frame_changed,
                   input ready);
   modport sink   (input valid, pixel_lit, luminance, contrast_now, inverted,
                   extended_mode, column, bank, byte_done, frame_changed,
                   output ready);
endinterface

`default_nettype wire

// File: sv/serial_mono_lcd_controller.sv
// ----------------------------------------------------------------------------
// Serial monochrome LCD controller
// Pin-event model of a serial mono LCD with bank-organized frame memory.
// ----------------------------------------------------------------------------
// Each item is one pin event or one pixel read and gives exactly one result.
// The transfer cycle executes the event and starts the frame memory access;
// the result register is loaded from the finish state once the output slot is
// free, which frees the input side while the result waits for its transfer.
// The frame memory holds one byte per column and eight-row bank,
// ceil(ROWS/8)*COLUMNS bytes (504 by default), cleared by a sweep of one byte
// per cycle; after block reset and after each reset-pin-low item no item is
// taken until the sweep has finished.
`default_nettype none

module serial_mono_lcd_controller import slcd_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input logic        clock,
   input logic        reset,
   slcd_req_if.sink   req_chan,
   slcd_rsp_if.source rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          ready_w;
   logic          valid_w;

   slcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .req_ready (ready_w),
      .rsp_valid (valid_w),
      .cmd       (cmd)
   );

   slcd_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_chan.kind),
      .req_level         (req_chan.level),
      .req_read_x        (req_chan.read_x),
      .req_read_y        (req_chan.read_y),
      .rsp_pixel_lit     (rsp_chan.pixel_lit),
      .rsp_luminance     (rsp_chan.luminance),
      .rsp_contrast_now  (rsp_chan.contrast_now),
      .rsp_inverted      (rsp_chan.inverted),
      .rsp_extended_mode (rsp_chan.extended_mode),
      .rsp_column        (rsp_chan.column),
      .rsp_bank          (rsp_chan.bank),
      .rsp_byte_done     (rsp_chan.byte_done),
      .rsp_frame_changed (rsp_chan.frame_changed)
   );

   assign req_chan.ready = ready_w;
   assign rsp_chan.valid = valid_w;

`ifndef SYNTHESIS
   // No transfer while the clear sweep owns the memory
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !(req_chan.valid && req_chan.ready))
      else $error("item accepted during frame memory clear");

   // An accepted item blocks the input for the following cycle
   a_two_cycle_item: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |=> !req_chan.ready)
      else $error("input ready right after a transfer");

   // A loaded result is presented on the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_chan.valid)
      else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// File: sv/slcd_ctrl.sv
// ----------------------------------------------------------------------------
// Serial monochrome LCD controller sequencer
// Sequences item acceptance, result loading and frame memory clear sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_ctrl import slcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output logic          req_ready,
   output logic          rsp_valid,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = status.clear_req ? ST_CLEAR : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs and commands
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.take_item  = (state_ff == ST_IDLE) && req_valid;
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.load_rsp   = (state_ff == ST_FINISH) && rsp_free;
      rsp_valid_in   = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   // State and result-valid registers; reset starts a clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/slcd_dp.sv
// ----------------------------------------------------------------------------
// Serial monochrome LCD controller datapath
// Serial shifter, command decode, cursor, frame memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_dp import slcd_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [2:0]    req_kind,
   input  logic          req_level,
   input  logic [6:0]    req_read_x,
   input  logic [5:0]    req_read_y,
   output logic          rsp_pixel_lit,
   output logic [7:0]    rsp_luminance,
   output logic [6:0]    rsp_contrast_now,
   output logic          rsp_inverted,
   output logic          rsp_extended_mode,
   output logic [6:0]    rsp_column,
   output logic [2:0]    rsp_bank,
   output logic          rsp_byte_done,
   output logic          rsp_frame_changed
);

   localparam int BANKS_USED = (ROWS + 7) / 8;
   localparam int MEM_DEPTH  = BANKS_USED * COLUMNS;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);

   // Next cursor bank after a column wrap, four bits per current bank
   function automatic logic [31:0] make_bank_next();
      logic [31:0] t;
      t = '0;
      for (int i = 0; i < 8; i++) begin
         t[4*i +: 4] = 4'((i + 1) % (ROWS / 8));
      end
      return t;
   endfunction

   localparam logic [31:0] BANK_NEXT = make_bank_next();

   // Architectural state
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bitcnt_ff, bitcnt_in;
   logic       din_ff, din_in;
   logic       dmode_ff, dmode_in;
   logic       inrst_ff, inrst_in;
   logic       sel_ff, sel_in;
   logic       ext_ff, ext_in;
   logic [6:0] contrast_ff, contrast_in;
   logic       invert_ff, invert_in;
   logic [6:0] col_ff, col_in;
   logic [2:0] bank_ff, bank_in;
   logic       changed_ff, changed_in;

   // Per-item bookkeeping
   logic       pend_clear_ff, pend_clear_in;
   logic       is_read_ff, is_read_in;
   logic       in_range_ff, in_range_in;
   logic [2:0] bit_sel_ff, bit_sel_in;
   logic       done_ff, done_in;

   // Memory and clear sweep
   logic [7:0]        mem_ram [MEM_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] wr_addr_data, rd_addr, mem_wa;
   logic [7:0]        mem_wd;
   logic              mem_we, data_wr, rd_en;

   // Result register
   logic       lit_ff;
   logic [7:0] lum_ff;
   logic [6:0] out_contrast_ff;
   logic       out_invert_ff, out_ext_ff, out_done_ff, out_changed_ff;
   logic [6:0] out_col_ff;
   logic [2:0] out_bank_ff;

   // Helpers
   logic [7:0] shift_next;
   logic [3:0] cnt_next;
   logic [3:0] bank_wrap_w;
   logic       data_fits, col_at_end, read_in_range;
   logic       lit_w;
   logic [7:0] lum_on, lum_w;

   assign shift_next    = {shift_ff[6:0], din_ff};
   assign cnt_next      = bitcnt_ff + 4'd1;
   assign bank_wrap_w   = BANK_NEXT[{bank_ff, 2'b00} +: 4];
   assign data_fits     = (col_ff < 7'(COLUMNS)) && ({1'b0, bank_ff} < 4'(BANKS_USED));
   assign col_at_end    = ({1'b0, col_ff} + 8'd1) >= 8'(COLUMNS);
   assign read_in_range = (req_read_x < 7'(COLUMNS)) && ({1'b0, req_read_y} < 7'(ROWS));
   assign wr_addr_data  = ADDR_W'(bank_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign rd_addr       = ADDR_W'(req_read_y[5:3]) * ADDR_W'(COLUMNS) + ADDR_W'(req_read_x);

   // Execute one pin event on the transfer edge
   always_comb begin
      shift_in      = shift_ff;
      bitcnt_in     = bitcnt_ff;
      din_in        = din_ff;
      dmode_in      = dmode_ff;
      inrst_in      = inrst_ff;
      sel_in        = sel_ff;
      ext_in        = ext_ff;
      contrast_in   = contrast_ff;
      invert_in     = invert_ff;
      col_in        = col_ff;
      bank_in       = bank_ff;
      changed_in    = changed_ff;
      pend_clear_in = pend_clear_ff;
      is_read_in    = is_read_ff;
      in_range_in   = in_range_ff;
      bit_sel_in    = bit_sel_ff;
      done_in       = done_ff;
      data_wr       = 1'b0;
      rd_en         = 1'b0;
      if (cmd.take_item) begin
         pend_clear_in = 1'b0;
         is_read_in    = 1'b0;
         done_in       = 1'b0;
         in_range_in   = read_in_range;
         bit_sel_in    = req_read_y[2:0];
         case (kind_type'(req_kind))
            KIND_CLOCK: begin
               if (sel_ff && req_level) begin
                  if (cnt_next[3]) begin
                     shift_in  = 8'd0;
                     bitcnt_in = 4'd0;
                     done_in   = 1'b1;
                     if (dmode_ff) begin
                        // Data byte: store column slice, advance cursor
                        if (!inrst_ff) begin
                           data_wr = data_fits;
                           if (data_fits) changed_in = 1'b1;
                           if (col_at_end) begin
                              col_in  = 7'd0;
                              bank_in = bank_wrap_w[2:0];
                           end else begin
                              col_in = col_ff + 7'd1;
                           end
                        end
                     end else if (shift_next != 8'd0) begin
                        // Command byte
                        if ((shift_next & CMD_FUNC_MASK) == CMD_FUNC_SET) begin
                           ext_in = (shift_next & CMD_FUNC_EXT) != 8'd0;
                        end else if (ext_ff) begin
                           if ((shift_next & CMD_HIGH_BIT) != 8'd0)
                              contrast_in = 7'(shift_next & CMD_X_MASK);
                        end else if ((shift_next & CMD_HIGH_BIT) != 8'd0) begin
                           col_in = 7'(shift_next & CMD_X_MASK);
                        end else if ((shift_next & CMD_SET_Y) != 8'd0) begin
                           bank_in = 3'(shift_next & CMD_Y_MASK);
                        end else if ((shift_next & CMD_RESERVED) != 8'd0) begin
                           invert_in = invert_ff;
                        end else if ((shift_next & CMD_DISPLAY) != 8'd0) begin
                           invert_in = (shift_next & CMD_INV_BITS) == CMD_INV_BITS;
                        end
                     end
                  end else begin
                     shift_in  = shift_next;
                     bitcnt_in = cnt_next;
                  end
               end
            end
            KIND_DIN: begin
               din_in = req_level;
            end
            KIND_DC: begin
               dmode_in = req_level;
            end
            KIND_RST: begin
               inrst_in      = !req_level;
               pend_clear_in = !req_level;
            end
            KIND_SEL: begin
               sel_in = !req_level;
            end
            KIND_READ: begin
               is_read_in = 1'b1;
               rd_en      = read_in_range;
            end
            default: begin
               rd_en = 1'b0;
            end
         endcase
      end
   end

   // Single write port shared by clear sweep and data writes
   assign mem_we = cmd.clear_step || data_wr;
   assign mem_wa = cmd.clear_step ? clr_addr_ff : wr_addr_data;
   assign mem_wd = cmd.clear_step ? 8'd0 : shift_next;

   always_ff @(posedge clock) begin
      if (mem_we) mem_ram[mem_wa] <= mem_wd;
      if (rd_en) rd_data_ff <= mem_ram[rd_addr];
   end

   assign status.clear_last = (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1));
   assign status.clear_req  = pend_clear_ff;

   // Architectural and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= 8'd0;
         bitcnt_ff     <= 4'd0;
         din_ff        <= 1'b0;
         dmode_ff      <= 1'b0;
         inrst_ff      <= 1'b0;
         sel_ff        <= 1'b1;
         ext_ff        <= 1'b0;
         contrast_ff   <= 7'd0;
         invert_ff     <= 1'b0;
         col_ff        <= 7'd0;
         bank_ff       <= 3'd0;
         changed_ff    <= 1'b1;
         pend_clear_ff <= 1'b0;
         is_read_ff    <= 1'b0;
         done_ff       <= 1'b0;
         clr_addr_ff   <= '0;
      end else begin
         shift_ff      <= shift_in;
         bitcnt_ff     <= bitcnt_in;
         din_ff        <= din_in;
         dmode_ff      <= dmode_in;
         inrst_ff      <= inrst_in;
         sel_ff        <= sel_in;
         ext_ff        <= ext_in;
         contrast_ff   <= contrast_in;
         invert_ff     <= invert_in;
         col_ff        <= col_in;
         bank_ff       <= bank_in;
         changed_ff    <= changed_in;
         pend_clear_ff <= pend_clear_in;
         is_read_ff    <= is_read_in;
         done_ff       <= done_in;
         // Advance the clear sweep, wrap to zero at the end
         if (cmd.clear_step)
            clr_addr_ff <= status.clear_last ? '0 : clr_addr_ff + 1'b1;
      end
   end

   // Read-side bookkeeping
   always_ff @(posedge clock) begin
      in_range_ff <= in_range_in;
      bit_sel_ff  <= bit_sel_in;
   end

   // Form the result from the stored read data
   assign lit_w  = is_read_ff && in_range_ff && rd_data_ff[bit_sel_ff];
   assign lum_on = LUM_FULL - {1'b0, contrast_ff};
   assign lum_w  = !is_read_ff ? 8'd0 : ((lit_w ^ invert_ff) ? lum_on : LUM_OFF);

   // Result register; loads when the output slot frees
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         lit_ff          <= lit_w;
         lum_ff          <= lum_w;
         out_contrast_ff <= contrast_ff;
         out_invert_ff   <= invert_ff;
         out_ext_ff      <= ext_ff;
         out_col_ff      <= col_ff;
         out_bank_ff     <= bank_ff;
         out_done_ff     <= done_ff;
         out_changed_ff  <= changed_ff;
      end
   end

   assign rsp_pixel_lit     = lit_ff;
   assign rsp_luminance     = lum_ff;
   assign rsp_contrast_now  = out_contrast_ff;
   assign rsp_inverted      = out_invert_ff;
   assign rsp_extended_mode = out_ext_ff;
   assign rsp_column        = out_col_ff;
   assign rsp_bank          = out_bank_ff;
   assign rsp_byte_done     = out_done_ff;
   assign rsp_frame_changed = out_changed_ff;

endmodule

`default_nettype wire

// File: tb/serial_mono_lcd_controller_tb.sv
// ----------------------------------------------------------------------------
// Serial monochrome LCD controller testbench
// Feeds pin events and pixel reads through the request channel and checks
// every result against an in-bench model of the panel: shift register,
// command decode, cursor, frame memory and luminance. Runs four flow-control
// phases and random bit-banged byte traffic with noise and reset pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_mono_lcd_controller_tb;
   import slcd_pkg::*;

   localparam int COLUMNS = DEF_COLUMNS;
   localparam int ROWS    = DEF_ROWS;
   localparam int BANKS   = ROWS / 8;

   // Kind codes the block leaves unused
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0] kind;
      logic       level;
      logic [6:0] read_x;
      logic [5:0] read_y;
   } pin_event_type;

   typedef struct packed {
      logic       pixel_lit;
      logic [7:0] luminance;
      logic [6:0] contrast_now;
      logic       inverted;
      logic       extended_mode;
      logic [6:0] column;
      logic [2:0] bank;
      logic       byte_done;
      logic       frame_changed;
   } panel_status_type;

   logic clock;
   logic reset;

   slcd_req_if req_bus ();
   slcd_rsp_if rsp_bus ();

   serial_mono_lcd_controller u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Panel model state
   logic [0:COLUMNS*ROWS-1] panel_pixels;
   logic [7:0] shift_reg;
   logic [3:0] shift_bits;
   logic       din_pin;
   logic       dc_pin;
   logic       rst_pin_low;
   logic       chip_selected;
   logic       ext_instr;
   logic [6:0] contrast_val;
   logic       invert_on;
   logic [6:0] cur_col;
   logic [2:0] cur_bank;
   logic       frame_dirty;

   // Stimulus generator view of the pins
   logic gen_selected;
   logic gen_din;
   int   gen_bits;
   int   counted_items;

   pin_event_type    pin_event_q[$];
   panel_status_type panel_status_q[$];

   int sender_idle_pct;
   int rsp_stall_pct;
   int fault_count;
   int events_taken;
   int results_seen;
   int bytes_done;
   int reads_taken;
   int reads_lit;

   pin_event_type    next_ev;
   pin_event_type    bus_ev;
   panel_status_type want_status;
   panel_status_type got_status;

   // Clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic string show_status(panel_status_type s);
      return $sformatf({"lit=%0d lum=%0d con=%0d inv=%0d ext=%0d ",
                        "col=%0d bank=%0d done=%0d chg=%0d"},
                       s.pixel_lit, s.luminance, s.contrast_now, s.inverted,
                       s.extended_mode, s.column, s.bank, s.byte_done, s.frame_changed);
   endfunction

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   function automatic void reset_panel();
      panel_pixels  = '0;
      shift_reg     = '0;
      shift_bits    = '0;
      din_pin       = 1'b0;
      dc_pin        = 1'b0;
      rst_pin_low   = 1'b0;
      chip_selected = 1'b1;
      ext_instr     = 1'b0;
      contrast_val  = '0;
      invert_on     = 1'b0;
      cur_col       = '0;
      cur_bank      = '0;
      frame_dirty   = 1'b1;
   endfunction

   // Decode one command byte against the basic or extended set
   function automatic void run_command(logic [7:0] b);
      if (b == 8'h00) return;
      if ((b & CMD_FUNC_MASK) == CMD_FUNC_SET) begin
         ext_instr = (b & CMD_FUNC_EXT) != 0;
         return;
      end
      if (ext_instr) begin
         if ((b & CMD_HIGH_BIT) != 0) contrast_val = b[6:0] & CMD_X_MASK[6:0];
         return;
      end
      if ((b & CMD_HIGH_BIT) != 0) begin
         cur_col = b[6:0] & CMD_X_MASK[6:0];
      end else if ((b & CMD_SET_Y) != 0) begin
         cur_bank = b[2:0] & CMD_Y_MASK[2:0];
      end else if ((b & CMD_RESERVED) != 0) begin
         // reserved, no effect
      end else if ((b & CMD_DISPLAY) != 0) begin
         invert_on = (b & CMD_INV_BITS) == CMD_INV_BITS;
      end
   endfunction

   // Store eight vertical pixels at the cursor, then advance the cursor
   function automatic void write_data_byte(logic [7:0] b);
      int row;
      if (rst_pin_low) return;
      if (cur_col < COLUMNS) begin
         for (int i = 0; i < 8; i++) begin
            row = int'(cur_bank) * 8 + i;
            if (row < ROWS) begin
               panel_pixels[row * COLUMNS + int'(cur_col)] = b[i];
               frame_dirty = 1'b1;
            end
         end
      end
      if (int'(cur_col) + 1 >= COLUMNS) begin
         cur_col  = '0;
         cur_bank = 3'((int'(cur_bank) + 1) % BANKS);
      end else begin
         cur_col = cur_col + 7'd1;
      end
   endfunction

   // Apply one pin event or read and return the status it reports
   function automatic panel_status_type step_panel(pin_event_type ev);
      panel_status_type st;
      logic [7:0]       lit_lum;
      logic [7:0]       dark_lum;
      logic [7:0]       swap;
      st = '0;
      case (ev.kind)
         KIND_CLOCK: begin
            if (chip_selected && ev.level) begin
               shift_reg  = {shift_reg[6:0], din_pin};
               shift_bits = shift_bits + 4'd1;
               if (shift_bits >= 4'd8) begin
                  if (dc_pin) write_data_byte(shift_reg);
                  else run_command(shift_reg);
                  shift_reg    = '0;
                  shift_bits   = '0;
                  st.byte_done = 1'b1;
               end
            end
         end
         KIND_DIN: din_pin = ev.level;
         KIND_DC:  dc_pin = ev.level;
         KIND_RST: begin
            rst_pin_low = !ev.level;
            if (rst_pin_low) panel_pixels = '0;
         end
         KIND_SEL: chip_selected = !ev.level;
         KIND_READ: begin
            lit_lum  = LUM_FULL - {1'b0, contrast_val};
            dark_lum = LUM_OFF;
            if (invert_on) begin
               swap     = lit_lum;
               lit_lum  = dark_lum;
               dark_lum = swap;
            end
            if (ev.read_x < COLUMNS && ev.read_y < ROWS) begin
               st.pixel_lit = panel_pixels[int'(ev.read_y) * COLUMNS + int'(ev.read_x)];
            end
            st.luminance = st.pixel_lit ? lit_lum : dark_lum;
         end
         default: ;
      endcase
      st.contrast_now  = contrast_val;
      st.inverted      = invert_on;
      st.extended_mode = ext_instr;
      st.column        = cur_col;
      st.bank          = cur_bank;
      st.frame_changed = frame_dirty;
      return st;
   endfunction

   // Queue one item and track the pins as the generator left them
   task automatic push_event(logic [2:0] k, logic lvl, logic [6:0] x, logic [5:0] y);
      pin_event_q.push_back('{kind: k, level: lvl, read_x: x, read_y: y});
      counted_items++;
      if (k == KIND_CLOCK && lvl && gen_selected) gen_bits = (gen_bits + 1) % 8;
      if (k == KIND_DIN) gen_din = lvl;
      if (k == KIND_SEL) gen_selected = !lvl;
   endtask

   task automatic push_pin(logic [2:0] k, logic lvl);
      push_event(k, lvl, 7'($urandom_range(127)), 6'($urandom_range(63)));
   endtask

   task automatic push_read(int x, int y);
      push_event(KIND_READ, 1'($urandom_range(1)), 7'(x), 6'(y));
   endtask

   task automatic push_random_read();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) push_read($urandom_range(7), $urandom_range(15));
      else if (pick < 85) push_read($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1));
      else push_read($urandom_range(127), $urandom_range(63));
   endtask

   // Bit-bang one byte MSB first, finishing any partial byte beforehand
   task automatic send_serial_byte(logic [7:0] b, logic dc);
      if (!gen_selected) push_pin(KIND_SEL, 1'b0);
      while (gen_bits != 0) push_pin(KIND_CLOCK, 1'b1);
      push_pin(KIND_DC, dc);
      for (int i = 7; i >= 0; i--) begin
         if (gen_din != b[i] || $urandom_range(3) == 0) push_pin(KIND_DIN, b[i]);
         if ($urandom_range(2) == 0) push_pin(KIND_CLOCK, 1'b0);
         push_pin(KIND_CLOCK, 1'b1);
      end
   endtask

   function automatic logic [7:0] pick_command();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0: return 8'h00;
         1, 2: return CMD_FUNC_SET | 8'($urandom_range(1));
         3: return CMD_FUNC_SET | 8'($urandom_range(7));
         4: begin
            if ($urandom_range(1)) return CMD_HIGH_BIT | 8'($urandom_range(7));
            if ($urandom_range(2) != 0) return CMD_HIGH_BIT | 8'($urandom_range(83, 76));
            return CMD_HIGH_BIT | 8'($urandom_range(127, 84));
         end
         5: return CMD_SET_Y | 8'($urandom_range(7));
         6: return CMD_DISPLAY | 8'($urandom_range(7));
         7: return CMD_RESERVED | 8'($urandom_range(15));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic fill_random_phase(int target);
      int start;
      int pick;
      int n;
      start = counted_items;
      while (counted_items - start < target) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            n = $urandom_range(6, 1);
            repeat (n) send_serial_byte(8'($urandom_range(255)), 1'b1);
         end else if (pick < 60) begin
            send_serial_byte(pick_command(), 1'b0);
         end else if (pick < 80) begin
            n = $urandom_range(4, 1);
            repeat (n) push_random_read();
         end else if (pick < 83) begin
            // reset pulse, sometimes with a data byte that must be dropped
            push_pin(KIND_RST, 1'b0);
            if ($urandom_range(1)) send_serial_byte(8'($urandom_range(255)), 1'b1);
            push_pin(KIND_RST, 1'b1);
         end else if (pick < 90) begin
            // clocks while deselected are ignored
            push_pin(KIND_SEL, 1'b1);
            n = $urandom_range(3, 1);
            repeat (n) begin
               push_pin(KIND_DIN, 1'($urandom_range(1)));
               push_pin(KIND_CLOCK, 1'b1);
            end
            push_pin(KIND_SEL, 1'b0);
         end else begin
            push_event(3'($urandom_range(7)), 1'($urandom_range(1)),
                       7'($urandom_range(127)), 6'($urandom_range(63)));
         end
      end
   endtask

   task automatic wait_drained();
      while (pin_event_q.size() != 0 || req_bus.valid || panel_status_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: predict on each transfer, then hold or advance the request
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bus_ev = {req_bus.kind, req_bus.level, req_bus.read_x, req_bus.read_y};
            want_status = step_panel(bus_ev);
            panel_status_q.push_back(want_status);
            events_taken++;
            if (want_status.byte_done) bytes_done++;
            if (bus_ev.kind == KIND_READ) begin
               reads_taken++;
               if (want_status.pixel_lit) reads_lit++;
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pin_event_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_ev = pin_event_q.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.kind   <= next_ev.kind;
               req_bus.level  <= next_ev.level;
               req_bus.read_x <= next_ev.read_x;
               req_bus.read_y <= next_ev.read_y;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, compare each result transfer in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= $urandom_range(99) >= rsp_stall_pct;
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            got_status = {rsp_bus.pixel_lit, rsp_bus.luminance, rsp_bus.contrast_now,
                          rsp_bus.inverted, rsp_bus.extended_mode, rsp_bus.column,
                          rsp_bus.bank, rsp_bus.byte_done, rsp_bus.frame_changed};
            if (panel_status_q.size() == 0) begin
               note_fault($sformatf("unexpected result %0d: %s", results_seen,
                                    show_status(got_status)));
            end else begin
               want_status = panel_status_q.pop_front();
               if (got_status !== want_status) begin
                  note_fault($sformatf("result %0d mismatch\n  want %s\n  got  %s",
                                       results_seen, show_status(want_status),
                                       show_status(got_status)));
               end
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int send_pct[4];
      int stall_pct[4];
      send_pct  = '{0, 64, 0, 12};
      stall_pct = '{0, 0, 64, 12};
      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.kind   = KIND_CLOCK;
      req_bus.level  = 1'b0;
      req_bus.read_x = '0;
      req_bus.read_y = '0;
      rsp_bus.ready  = 1'b0;
      gen_selected   = 1'b1;
      gen_din        = 1'b0;
      gen_bits       = 0;
      counted_items  = 0;
      fault_count    = 0;
      events_taken   = 0;
      results_seen   = 0;
      bytes_done     = 0;
      reads_taken    = 0;
      reads_lit      = 0;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      reset_panel();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: read corners in and out of the panel, unused kinds,
      // deselected clock, every pin, reset pin low and back
      push_read(0, 0);
      push_read(COLUMNS - 1, ROWS - 1);
      push_read(COLUMNS, ROWS);
      push_read(127, 63);
      push_pin(KIND_SPARE_A, 1'b1);
      push_pin(KIND_SPARE_B, 1'b0);
      push_pin(KIND_SEL, 1'b1);
      push_pin(KIND_CLOCK, 1'b1);
      push_pin(KIND_SEL, 1'b0);
      push_pin(KIND_CLOCK, 1'b0);
      push_pin(KIND_DIN, 1'b1);
      push_pin(KIND_DIN, 1'b0);
      push_pin(KIND_DC, 1'b1);
      push_pin(KIND_DC, 1'b0);
      push_pin(KIND_RST, 1'b0);
      push_read(5, 5);
      push_pin(KIND_RST, 1'b1);

      // Random traffic under each flow-control phase; drain between phases
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = send_pct[p];
         rsp_stall_pct   = stall_pct[p];
         fill_random_phase(358);
         wait_drained();
      end
      repeat (8) @(posedge clock);

      $display("covered %0d items, %0d results, %0d serial bytes completed",
               events_taken, results_seen, bytes_done);
      $display("pixel reads %0d, of which %0d lit; %0d faults", reads_taken, reads_lit,
               fault_count);
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("timeout waiting for results");
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
